// ----- design/md4he_pkg.sv -----
// ----------------------------------------------------------------------------
// md4he_pkg
// Shared types, constants and step tables for the MD4 hash engine.
// ----------------------------------------------------------------------------
package md4he_pkg;

  localparam logic [31:0] IV_A     = 32'h67452301;
  localparam logic [31:0] IV_B     = 32'hefcdab89;
  localparam logic [31:0] IV_C     = 32'h98badcfe;
  localparam logic [31:0] IV_D     = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5a827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
  localparam logic [7:0]  PAD_MARK = 8'd128;

  localparam int unsigned NUM_STEPS = 48;
  localparam int unsigned NUM_WORDS = 16;
  localparam int unsigned WORD_BYTES = 4;
  // Position at and above which the pad marker leaves no room for the length.
  localparam logic [5:0]  LEN_SLOT  = 6'd56;
  localparam logic [5:0]  LAST_STEP = 6'(NUM_STEPS - 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } md4he_in_t;

  typedef struct packed {
    logic [63:0] digest_low;
    logic [63:0] digest_high;
  } md4he_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       absorb;
    logic       pad;
    logic       len_block;
    logic       step;
    logic [5:0] step_idx;
    logic       add_chain;
    logic       flush;
  } md4he_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_last;
    logic pad_two;
  } md4he_sts_t;

  // Rotate amount for a step: by round and by position within the group of four.
  function automatic logic [4:0] step_shift(input logic [1:0] round, input logic [1:0] k);
    logic [4:0] s;
    s = 5'd3;
    unique case (round)
      2'd0: begin
        unique case (k)
          2'd0: s = 5'd3;
          2'd1: s = 5'd7;
          2'd2: s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      2'd1: begin
        unique case (k)
          2'd0: s = 5'd3;
          2'd1: s = 5'd5;
          2'd2: s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        unique case (k)
          2'd0: s = 5'd3;
          2'd1: s = 5'd9;
          2'd2: s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

  // Message word used by a step.
  function automatic logic [3:0] step_word(input logic [1:0] round, input logic [3:0] j);
    logic [3:0] w;
    unique case (round)
      2'd0:    w = j;
      2'd1:    w = {j[1:0], j[3:2]};
      default: w = {j[0], j[1], j[2], j[3]};
    endcase
    return w;
  endfunction

endpackage

// ----- design/md4_hash_engine_top.sv -----
// ----------------------------------------------------------------------------
// md4_hash_engine_top
// Streaming MD4 message digest engine, one message byte per transaction.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_data) carries one byte per
// transaction with a byte_valid flag and a last flag; a transaction with
// byte_valid low and last high closes a message, including an empty one.
// The output channel (out_valid, out_stall, out_data) carries one 128-bit
// digest per message, split into two little-endian 64-bit halves.
// A byte that neither completes a 64-byte block nor closes the message leaves
// in_stall low. A byte that completes a block holds in_stall high while 48
// MD4 steps run one per cycle on a single step unit and their result is then
// added into the chaining words. Closing a message runs a padding step, the
// compression of each final block, a step that lays out the length block
// when two are needed, and a step that loads the digest register; out_valid
// rises as the digest is loaded.
// The digest sits in an output register: the next message may be absorbed
// while it waits, but that message's digest is not loaded until the
// previous one has been taken. Synchronous reset restores the initial
// chaining words, clears the byte count and drops out_valid.
// ----------------------------------------------------------------------------
module md4_hash_engine_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  md4he_pkg::md4he_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output md4he_pkg::md4he_out_t  out_data
);
  import md4he_pkg::*;

  md4he_cmd_t cmd;
  md4he_sts_t sts;

  md4he_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  md4he_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ----- design/md4he_ctrl.sv -----
// ----------------------------------------------------------------------------
// md4he_ctrl
// Controller: input and output handshakes, compression sequencing, padding.
// ----------------------------------------------------------------------------
module md4he_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  md4he_pkg::md4he_in_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  md4he_pkg::md4he_sts_t sts,
  output md4he_pkg::md4he_cmd_t cmd
);
  import md4he_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_COMP  = 6'b000010,
    ST_ADD   = 6'b000100,
    ST_PAD   = 6'b001000,
    ST_LEN   = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

  // What follows the running compression.
  typedef enum logic [2:0] {
    KIND_DATA  = 3'b001,
    KIND_PAD1  = 3'b010,
    KIND_FINAL = 3'b100
  } kind_t;

  state_t     state_r, state_nxt;
  kind_t      kind_r, kind_nxt;
  logic [5:0] step_r, step_nxt;
  logic       fin_r, fin_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    step_nxt      = step_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.step_idx  = step_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.absorb = in_data.byte_valid;
          if (in_data.byte_valid && sts.pos_last) begin
            state_nxt = ST_COMP;
            kind_nxt  = KIND_DATA;
            step_nxt  = '0;
            fin_nxt   = in_data.last;
          end else if (in_data.last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 6'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_chain = 1'b1;
        unique case (kind_r)
          KIND_DATA:  state_nxt = fin_r ? ST_PAD : ST_IDLE;
          KIND_PAD1:  state_nxt = ST_LEN;
          KIND_FINAL: state_nxt = ST_FLUSH;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_PAD: begin
        cmd.pad   = 1'b1;
        state_nxt = ST_COMP;
        step_nxt  = '0;
        kind_nxt  = sts.pad_two ? KIND_PAD1 : KIND_FINAL;
      end
      ST_LEN: begin
        cmd.len_block = 1'b1;
        state_nxt     = ST_COMP;
        step_nxt      = '0;
        kind_nxt      = KIND_FINAL;
      end
      ST_FLUSH: begin
        // Wait until the previous digest has left the output register.
        if (!out_valid_r) begin
          cmd.flush     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= KIND_DATA;
      step_r      <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      step_r      <= step_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/md4he_datapath.sv -----
// ----------------------------------------------------------------------------
// md4he_datapath
// Block store, byte counter, chaining words, MD4 step unit and digest register.
// ----------------------------------------------------------------------------
module md4he_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  md4he_pkg::md4he_in_t  in_data,
  input  md4he_pkg::md4he_cmd_t cmd,
  output md4he_pkg::md4he_sts_t sts,
  output md4he_pkg::md4he_out_t out_data
);
  import md4he_pkg::*;

  logic [31:0] blk_r   [NUM_WORDS];
  logic [31:0] blk_nxt [NUM_WORDS];
  logic [31:0] chain_r [4];
  logic [31:0] work_r  [4];
  logic [5:0]  pos_r;
  logic [63:0] cnt_r;
  logic [63:0] bit_len;
  md4he_out_t  out_r;

  logic [1:0]  round;
  logic [3:0]  widx;
  logic [31:0] f_val, k_val, sum, rot;
  logic [63:0] rot_wide;
  logic [4:0]  shamt;

  assign bit_len     = {cnt_r[60:0], 3'b000};
  assign sts.pos_last = (pos_r == 6'd63);
  assign sts.pad_two  = (pos_r >= LEN_SLOT);
  assign out_data    = out_r;

  // Block store update: byte writes, padding and the length block.
  always_comb begin
    logic [5:0] idx;
    for (int w = 0; w < NUM_WORDS; w++) begin
      blk_nxt[w] = blk_r[w];
    end
    for (int w = 0; w < NUM_WORDS; w++) begin
      for (int k = 0; k < WORD_BYTES; k++) begin
        idx = 6'(w * WORD_BYTES + k);
        if (cmd.absorb && idx == pos_r) begin
          blk_nxt[w][k*8 +: 8] = in_data.data_byte;
        end
        if (cmd.pad) begin
          if (idx == pos_r) begin
            blk_nxt[w][k*8 +: 8] = PAD_MARK;
          end else if (idx > pos_r) begin
            blk_nxt[w][k*8 +: 8] = 8'd0;
          end
        end
        if (cmd.len_block) begin
          blk_nxt[w][k*8 +: 8] = 8'd0;
        end
      end
    end
    if ((cmd.pad && pos_r < LEN_SLOT) || cmd.len_block) begin
      blk_nxt[14] = bit_len[31:0];
      blk_nxt[15] = bit_len[63:32];
    end
  end

  // One MD4 step: the register being updated always sits in slot 0, the roles
  // rotate afterwards so that 48 steps leave them in their original places.
  always_comb begin
    round = cmd.step_idx[5:4];
    widx  = step_word(round, cmd.step_idx[3:0]);
    shamt = step_shift(round, cmd.step_idx[1:0]);
    unique case (round)
      2'd0: begin
        f_val = work_r[3] ^ (work_r[1] & (work_r[2] ^ work_r[3]));
        k_val = 32'd0;
      end
      2'd1: begin
        f_val = (work_r[1] & (work_r[2] | work_r[3])) | (work_r[2] & work_r[3]);
        k_val = K_ROUND2;
      end
      default: begin
        f_val = work_r[1] ^ work_r[2] ^ work_r[3];
        k_val = K_ROUND3;
      end
    endcase
    sum      = work_r[0] + f_val + blk_r[widx] + k_val;
    rot_wide = {sum, sum} << shamt;
    rot      = rot_wide[63:32];
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      blk_r[w] <= blk_nxt[w];
    end
    if (cmd.step) begin
      work_r[0] <= work_r[3];
      work_r[1] <= rot;
      work_r[2] <= work_r[1];
      work_r[3] <= work_r[2];
    end else begin
      for (int i = 0; i < 4; i++) begin
        work_r[i] <= chain_r[i];
      end
    end
    if (cmd.flush) begin
      out_r.digest_low  <= {chain_r[1], chain_r[0]};
      out_r.digest_high <= {chain_r[3], chain_r[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r[0] <= IV_A;
      chain_r[1] <= IV_B;
      chain_r[2] <= IV_C;
      chain_r[3] <= IV_D;
      pos_r      <= '0;
      cnt_r      <= '0;
    end else begin
      if (cmd.add_chain) begin
        for (int i = 0; i < 4; i++) begin
          chain_r[i] <= chain_r[i] + work_r[i];
        end
      end else if (cmd.flush) begin
        chain_r[0] <= IV_A;
        chain_r[1] <= IV_B;
        chain_r[2] <= IV_C;
        chain_r[3] <= IV_D;
      end
      if (cmd.flush) begin
        pos_r <= '0;
        cnt_r <= '0;
      end else if (cmd.absorb) begin
        pos_r <= pos_r + 6'd1;
        cnt_r <= cnt_r + 64'd1;
      end
    end
  end

endmodule
